// ----- sv/tpbd_pkg.sv -----
`default_nettype none
package tpbd_pkg;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_HANDLE_BITS = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int TIMEOUT_BITS = 20;
    localparam int LIMIT_BITS   = 6;
    localparam int CFG_BITS     = 20;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 20'd30;
    localparam logic [LIMIT_BITS-1:0]   LIMIT_RST   = 6'd32;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    localparam logic [2:0] REQ_ENQ      = 3'd0;
    localparam logic [2:0] REQ_DEQ_HEAD = 3'd1;
    localparam logic [2:0] REQ_DEQ_DEST = 3'd2;
    localparam logic [2:0] REQ_FIND     = 3'd3;
    localparam logic [2:0] REQ_TICK     = 3'd4;

    localparam logic [1:0] KIND_DONE     = 2'd0;
    localparam logic [1:0] KIND_AGED     = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;
    localparam logic [1:0] KIND_FULL_EXP = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ----- sv/tpbd_cell.sv -----
`default_nettype none
module tpbd_cell #(
    parameter int ADDR_BITS   = tpbd_pkg::DEF_ADDR_BITS,
    parameter int HANDLE_BITS = tpbd_pkg::DEF_HANDLE_BITS,
    parameter int TIME_BITS   = tpbd_pkg::DEF_TIME_BITS
) (
    input  wire                       i_clk,
    input  wire tpbd_pkg::t_cell_ctl  i_ctl,
    input  wire  [HANDLE_BITS-1:0]    i_ld_handle,
    input  wire  [ADDR_BITS-1:0]      i_ld_dest,
    input  wire  [TIME_BITS-1:0]      i_ld_expiry,
    input  wire  [HANDLE_BITS-1:0]    i_nb_handle,
    input  wire  [ADDR_BITS-1:0]      i_nb_dest,
    input  wire  [TIME_BITS-1:0]      i_nb_expiry,
    output logic [HANDLE_BITS-1:0]    o_handle,
    output logic [ADDR_BITS-1:0]      o_dest,
    output logic [TIME_BITS-1:0]      o_expiry
);
    import tpbd_pkg::*;

    logic [HANDLE_BITS-1:0] r_handle;
    logic [ADDR_BITS-1:0]   r_dest;
    logic [TIME_BITS-1:0]   r_expiry;

    // a load wins over the shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_handle <= i_ld_handle;
            r_dest   <= i_ld_dest;
            r_expiry <= i_ld_expiry;
        end else if (i_ctl.shift) begin
            r_handle <= i_nb_handle;
            r_dest   <= i_nb_dest;
            r_expiry <= i_nb_expiry;
        end
    end

    assign o_handle = r_handle;
    assign o_dest   = r_dest;
    assign o_expiry = r_expiry;
endmodule
`default_nettype wire

// ----- sv/timed_packet_buffer_by_destination_unit.sv -----
// channel | dir | tdata (low bit up)          | tuser     | tlast
// s       | in  | pkt_handle, dest_addr       | req_type  | -
// m       | out | out_handle, found           | result_kind | last result of a request
// cfg     | in  | i_cfg_we / i_cfg_idx / i_cfg_data, 0 hold_timeout, 1 queue_limit
//
// each request walks the cell row once per stored entry in each of its passes: enqueue
// and dequeues purge, dequeue by destination and find scan for the destination, tick
// makes no pass; add one step per overflow drop and one for the completion.
// one request in flight; a new one is taken only after its completion is registered.
// synchronous active-low reset empties the buffer and zeroes the clock.
// a full output register stalls the walk at the next step that has a result.
`default_nettype none
module timed_packet_buffer_by_destination_unit #(
    parameter int QUEUE_DEPTH = tpbd_pkg::DEF_QUEUE_DEPTH,
    parameter int ADDR_BITS   = tpbd_pkg::DEF_ADDR_BITS,
    parameter int HANDLE_BITS = tpbd_pkg::DEF_HANDLE_BITS,
    parameter int TIME_BITS   = tpbd_pkg::DEF_TIME_BITS,
    localparam int SD_W = ((HANDLE_BITS + ADDR_BITS + 7) / 8) * 8,
    localparam int MD_W = ((HANDLE_BITS + 1 + 7) / 8) * 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [SD_W-1:0]               i_s_tdata,   // pkt_handle, dest_addr
    input  wire  [2:0]                    i_s_tuser,   // req_type
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [MD_W-1:0]               o_m_tdata,   // out_handle, found
    output logic [1:0]                    o_m_tuser,   // result_kind
    output logic                          o_m_tlast,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_idx,
    input  wire  [tpbd_pkg::CFG_BITS-1:0] i_cfg_data
);
    import tpbd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = ((TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS) + 1;
    localparam logic [TIME_BITS-1:0]  TMAX   = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]         DEPTH  = CW'(QUEUE_DEPTH);
    localparam logic [LIMIT_BITS:0]   DEPTHL = (LIMIT_BITS + 1)'(QUEUE_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_PURGE, S_OVF, S_SCAN, S_DONE} t_state;

    t_state                  r_state;
    logic [TIMEOUT_BITS-1:0] r_timeout;
    logic [LIMIT_BITS-1:0]   r_limit;
    logic [CW-1:0]           r_count, r_left;
    logic [TIME_BITS-1:0]    r_now;
    logic [2:0]              r_req;
    logic [HANDLE_BITS-1:0]  r_handle, r_fhandle;
    logic [ADDR_BITS-1:0]    r_dest;
    logic                    r_found;
    logic                    r_ovalid, r_olast, r_ofound;
    logic [1:0]              r_okind;
    logic [HANDLE_BITS-1:0]  r_ohandle;

    t_cell_ctl               ctl [QUEUE_DEPTH];
    logic [HANDLE_BITS-1:0]  c_handle [QUEUE_DEPTH + 1];
    logic [ADDR_BITS-1:0]    c_dest   [QUEUE_DEPTH + 1];
    logic [TIME_BITS-1:0]    c_expiry [QUEUE_DEPTH + 1];

    logic                    pop, load, give;
    logic [CW-1:0]           load_idx;
    logic [HANDLE_BITS-1:0]  ld_handle;
    logic [ADDR_BITS-1:0]    ld_dest;
    logic [TIME_BITS-1:0]    ld_expiry, stamp;
    logic [SW-1:0]           sum;
    logic [LIMIT_BITS:0]     lim;
    logic                    free, head_exp, head_match, over;

    assign free       = !r_ovalid || i_m_tready;
    assign head_exp   = c_expiry[0] < r_now;
    assign head_match = c_dest[0] == r_dest;
    assign sum        = SW'(r_now) + SW'(r_timeout);
    assign stamp      = (sum > SW'(TMAX)) ? TMAX : sum[TIME_BITS-1:0];

    always_comb begin
        if (r_limit == '0) begin
            lim = (LIMIT_BITS + 1)'(1);
        end else if ({1'b0, r_limit} > DEPTHL) begin
            lim = DEPTHL;
        end else begin
            lim = {1'b0, r_limit};
        end
    end
    assign over = ((LIMIT_BITS + 1)'(r_count) >= lim) && (r_count != '0);

    // spare end of the row reads as zero
    assign c_handle[QUEUE_DEPTH] = '0;
    assign c_dest[QUEUE_DEPTH]   = '0;
    assign c_expiry[QUEUE_DEPTH] = '0;

    // row control: pop shifts toward the head, load writes one cell
    always_comb begin
        pop       = 1'b0;
        load      = 1'b0;
        give      = 1'b0;
        load_idx  = r_count - CW'(1);
        ld_handle = c_handle[0];
        ld_dest   = c_dest[0];
        ld_expiry = c_expiry[0];
        case (r_state)
            S_PURGE: begin
                if (r_left != '0) begin
                    if (head_exp) begin
                        pop  = free;
                        give = free;
                    end else begin
                        pop  = 1'b1;
                        load = 1'b1;
                    end
                end else if (r_req == REQ_DEQ_HEAD && r_count != '0) begin
                    pop = 1'b1;
                end
            end
            S_OVF: begin
                if (over) begin
                    pop  = free;
                    give = free;
                end else if (r_count != DEPTH) begin
                    load      = 1'b1;
                    load_idx  = r_count;
                    ld_handle = r_handle;
                    ld_dest   = r_dest;
                    ld_expiry = stamp;
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    pop  = 1'b1;
                    load = !(head_match && !r_found && r_req == REQ_DEQ_DEST);
                end
            end
            S_DONE: give = free;
            default: ;
        endcase
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        assign ctl[i].shift = pop;
        assign ctl[i].load  = load && (load_idx == CW'(i));
        tpbd_cell #(
            .ADDR_BITS(ADDR_BITS), .HANDLE_BITS(HANDLE_BITS), .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl[i]),
            .i_ld_handle (ld_handle),
            .i_ld_dest   (ld_dest),
            .i_ld_expiry (ld_expiry),
            .i_nb_handle (c_handle[i + 1]),
            .i_nb_dest   (c_dest[i + 1]),
            .i_nb_expiry (c_expiry[i + 1]),
            .o_handle    (c_handle[i]),
            .o_dest      (c_dest[i]),
            .o_expiry    (c_expiry[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIMEOUT_RST;
            r_limit   <= LIMIT_RST;
            r_count   <= '0;
            r_now     <= '0;
            r_ovalid  <= 1'b0;
            r_found   <= 1'b0;
            r_left    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data[TIMEOUT_BITS-1:0];
                end else begin
                    r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                end
            end
            if (r_ovalid && i_m_tready && !give) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_req    <= i_s_tuser;
                        r_handle <= i_s_tdata[HANDLE_BITS-1:0];
                        r_dest   <= i_s_tdata[HANDLE_BITS +: ADDR_BITS];
                        r_found  <= 1'b0;
                        r_left   <= r_count;
                        if (i_s_tuser inside {REQ_ENQ, REQ_DEQ_HEAD, REQ_DEQ_DEST}) begin
                            r_state <= S_PURGE;
                        end else if (i_s_tuser == REQ_FIND) begin
                            r_state <= S_SCAN;
                        end else begin
                            if (i_s_tuser == REQ_TICK && r_now != TMAX) begin
                                r_now <= r_now + TIME_BITS'(1);
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PURGE: begin
                    if (r_left != '0) begin
                        if (!head_exp) begin
                            r_left <= r_left - CW'(1);
                        end else if (free) begin
                            r_left    <= r_left - CW'(1);
                            r_count   <= r_count - CW'(1);
                            r_ovalid  <= 1'b1;
                            r_okind   <= KIND_AGED;
                            r_ohandle <= c_handle[0];
                            r_ofound  <= 1'b0;
                            r_olast   <= 1'b0;
                        end
                    end else if (r_req == REQ_ENQ) begin
                        r_state <= S_OVF;
                    end else if (r_req == REQ_DEQ_HEAD) begin
                        if (r_count != '0) begin
                            r_found   <= 1'b1;
                            r_fhandle <= c_handle[0];
                            r_count   <= r_count - CW'(1);
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_left  <= r_count;
                        r_state <= S_SCAN;
                    end
                end
                S_OVF: begin
                    if (over) begin
                        if (free) begin
                            r_count   <= r_count - CW'(1);
                            r_ovalid  <= 1'b1;
                            r_okind   <= (c_expiry[0] > r_now) ? KIND_FULL : KIND_FULL_EXP;
                            r_ohandle <= c_handle[0];
                            r_ofound  <= 1'b0;
                            r_olast   <= 1'b0;
                        end
                    end else begin
                        if (r_count != DEPTH) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_left != '0) begin
                        r_left <= r_left - CW'(1);
                        if (head_match && !r_found) begin
                            r_found   <= 1'b1;
                            r_fhandle <= c_handle[0];
                            if (r_req == REQ_DEQ_DEST) begin
                                r_count <= r_count - CW'(1);
                            end
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (free) begin
                        r_ovalid  <= 1'b1;
                        r_okind   <= KIND_DONE;
                        r_ohandle <= (r_found && r_req != REQ_FIND) ? r_fhandle : '0;
                        r_ofound  <= r_found;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = MD_W'({r_ofound, r_ohandle});

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH) else $error("entry count above depth");
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_olast |-> r_okind == KIND_DONE) else $error("last result not a completion");
    a_drop_nofound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !r_olast |-> !r_ofound) else $error("drop result with found set");
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready) else $error("second request taken in flight");
endmodule
`default_nettype wire
